[hdl/segment_mask_crossing_test_defines.svh]
// assertion macros used by the segment mask crossing test checker
`ifndef SEGMENT_MASK_CROSSING_TEST_DEFINES_SVH
`define SEGMENT_MASK_CROSSING_TEST_DEFINES_SVH

// same-cycle implication
`define SMC_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMC_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/segc_pkg.sv]
// shared constants and types of the segment mask crossing test
`default_nettype none

package segc_pkg;

	localparam int IMAGE_SIDE    = 512;
	localparam int FRACTION_BITS = 8;

	// pixel index bits
	localparam int AW   = $clog2(IMAGE_SIDE);
	// fixed point coordinate bits, z is one wider
	localparam int CW   = AW + FRACTION_BITS;
	localparam int ZW   = CW + 1;
	// root, radicand, sample count, denominator, remainder
	localparam int RW   = CW + 2;
	localparam int SW   = 2 * RW - 1;
	localparam int NW   = RW + 2 - FRACTION_BITS;
	localparam int DW   = NW + FRACTION_BITS;
	localparam int RSW  = DW + 2;
	// image size registers
	localparam int DIMW = 10;
	localparam logic [DIMW-1:0] DIM_RESET = DIMW'(IMAGE_SIDE);

	typedef enum logic {OP_WRITE = 1'b0, OP_QUERY = 1'b1} op_t;
	typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_t;

	typedef struct packed {
		logic          valid;
		logic          last;
		logic [AW-1:0] x;
		logic [AW-1:0] y;
	} smp_t;

	typedef struct packed {
		logic          rd_en;
		logic          wr_en;
		logic [AW-1:0] row;
		logic [AW-1:0] col;
		logic          white;
	} mask_req_t;

endpackage

`default_nettype wire

[hdl/segc_len.sv]
// segment length unit: squared distance and bitwise square root to sample count
`default_nettype none

module segc_len (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [segc_pkg::CW-1:0]    sx,
	input  wire logic [segc_pkg::CW-1:0]    sy,
	input  wire logic signed [segc_pkg::ZW-1:0] sz,
	input  wire logic [segc_pkg::CW-1:0]    ex,
	input  wire logic [segc_pkg::CW-1:0]    ey,
	input  wire logic signed [segc_pkg::ZW-1:0] ez,
	output logic                            done,
	output logic [segc_pkg::NW-1:0]         n
);
	import segc_pkg::*;

	typedef enum logic [1:0] {L_IDLE, L_SQ, L_ROOT} lst_t;

	localparam logic [SW-1:0] B_INIT = {1'b1, {(SW-1){1'b0}}};
	localparam logic [RW:0]   ROUND  = (RW+1)'((1 << FRACTION_BITS) - 1);

	lst_t            st_q;
	logic [1:0]      cnt_q;
	logic            done_q;
	logic [NW-1:0]   n_q;
	logic [ZW-1:0]   dx_q, dy_q, dz_q;
	logic [2*ZW-1:0] sq_q;
	logic [SW-1:0]   acc_q, r_q, b_q;

	logic [ZW-1:0]   op;
	logic [2*ZW-1:0] prod;
	logic [SW:0]     rb;
	logic            ge;
	logic [RW:0]     rootc, lenv;
	logic [NW-1:0]   nnext;
	logic [CW-1:0]   adx, ady;
	logic signed [ZW:0] dzs;
	logic [ZW:0]     adz;

	always_comb begin
		case (cnt_q)
			2'd0:    op = dx_q;
			2'd1:    op = dy_q;
			default: op = dz_q;
		endcase
	end

	assign prod  = op * op;
	assign rb    = {1'b0, r_q} + {1'b0, b_q};
	assign ge    = {1'b0, acc_q} >= rb;
	assign rootc = {1'b0, r_q[RW-1:0]} + (RW+1)'(acc_q != '0);
	assign lenv  = (rootc + ROUND) >> FRACTION_BITS;
	assign nnext = NW'(lenv) + NW'(1);

	assign adx = (sx >= ex) ? sx - ex : ex - sx;
	assign ady = (sy >= ey) ? sy - ey : ey - sy;
	assign dzs = {sz[ZW-1], sz} - {ez[ZW-1], ez};
	assign adz = dzs[ZW] ? (ZW+1)'(0) - dzs : dzs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				L_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						st_q <= L_SQ;
					end
				end
				L_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						st_q <= L_ROOT;
					end
				end
				L_ROOT: begin
					if (b_q == '0) begin
						n_q    <= nnext;
						done_q <= 1'b1;
						st_q   <= L_IDLE;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == L_IDLE && start) begin
			dx_q  <= ZW'(adx);
			dy_q  <= ZW'(ady);
			dz_q  <= adz[ZW-1:0];
			acc_q <= '0;
		end
		if (st_q == L_SQ) begin
			sq_q <= prod;
			if (cnt_q != 2'd0) begin
				acc_q <= acc_q + SW'(sq_q);
			end
			if (cnt_q == 2'd3) begin
				r_q <= '0;
				b_q <= B_INIT;
			end
		end
		if (st_q == L_ROOT && b_q != '0) begin
			if (ge) begin
				acc_q <= acc_q - rb[SW-1:0];
				r_q   <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign n    = n_q;

endmodule

`default_nettype wire

[hdl/segc_walk.sv]
// sample walker: exact quotient and remainder stepping along the segment
`default_nettype none

module segc_walk (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [segc_pkg::NW-1:0] n,
	input  wire logic [segc_pkg::CW-1:0] sx,
	input  wire logic [segc_pkg::CW-1:0] sy,
	input  wire logic [segc_pkg::CW-1:0] ex,
	input  wire logic [segc_pkg::CW-1:0] ey,
	output segc_pkg::smp_t               smp
);
	import segc_pkg::*;

	logic                  run_q;
	logic [NW-1:0]         cnt_q, n_q;
	logic [DW-1:0]         den_q;
	logic [AW-1:0]         qx_q, qy_q;
	logic signed [RSW-1:0] rx_q, ry_q;
	logic signed [CW:0]    ddx_q, ddy_q;

	logic [DW-1:0]         prodx, prody;
	logic signed [RSW-1:0] denx, tx, ty, rxn, ryn;
	logic [AW-1:0]         qxn, qyn;
	logic                  last;

	assign prodx = sx[FRACTION_BITS-1:0] * n;
	assign prody = sy[FRACTION_BITS-1:0] * n;
	assign denx  = $signed({2'b00, den_q});
	assign tx    = rx_q + $signed({{(RSW-CW-1){ddx_q[CW]}}, ddx_q});
	assign ty    = ry_q + $signed({{(RSW-CW-1){ddy_q[CW]}}, ddy_q});
	assign last  = (cnt_q == n_q);

	always_comb begin
		rxn = tx;
		qxn = qx_q;
		if (tx >= denx) begin
			rxn = tx - denx;
			qxn = qx_q + AW'(1);
		end else if (tx[RSW-1]) begin
			rxn = tx + denx;
			qxn = qx_q - AW'(1);
		end
		ryn = ty;
		qyn = qy_q;
		if (ty >= denx) begin
			ryn = ty - denx;
			qyn = qy_q + AW'(1);
		end else if (ty[RSW-1]) begin
			ryn = ty + denx;
			qyn = qy_q - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + NW'(1);
			if (last) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			den_q <= DW'(n) << FRACTION_BITS;
			qx_q  <= sx[CW-1:FRACTION_BITS];
			qy_q  <= sy[CW-1:FRACTION_BITS];
			rx_q  <= $signed({2'b00, prodx});
			ry_q  <= $signed({2'b00, prody});
			ddx_q <= $signed({1'b0, ex}) - $signed({1'b0, sx});
			ddy_q <= $signed({1'b0, ey}) - $signed({1'b0, sy});
		end else if (run_q) begin
			qx_q <= qxn;
			qy_q <= qyn;
			rx_q <= rxn;
			ry_q <= ryn;
		end
	end

	assign smp.valid = run_q;
	assign smp.last  = last;
	assign smp.x     = qx_q;
	assign smp.y     = qy_q;

endmodule

`default_nettype wire

[hdl/segc_mask.sv]
// mask memory: one row per word, clearing sweep, read-modify-write of one pixel
`default_nettype none

module segc_mask (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire segc_pkg::mask_req_t req,
	output logic                     busy,
	output logic                     rd_bit
);
	import segc_pkg::*;

	logic [IMAGE_SIDE-1:0] mem [IMAGE_SIDE];
	logic [IMAGE_SIDE-1:0] word_q;

	logic                  clr_q, wr_rd_q, wr_wb_q;
	logic [AW-1:0]         clr_row_q;
	logic [AW-1:0]         wrow_q, wcol_q, rd_col_s1;
	logic                  wwhite_q;

	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_addr;
	logic [IMAGE_SIDE-1:0] mem_wdata, merged;

	always_comb begin
		merged = word_q;
		merged[wcol_q] = wwhite_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = req.row;
		mem_wdata = merged;
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_addr  = clr_row_q;
			mem_wdata = '0;
		end else if (wr_wb_q) begin
			mem_we   = 1'b1;
			mem_addr = wrow_q;
		end else if (wr_rd_q) begin
			mem_re   = 1'b1;
			mem_addr = wrow_q;
		end else begin
			mem_re = req.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			word_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
			wr_rd_q   <= 1'b0;
			wr_wb_q   <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_row_q <= clr_row_q + AW'(1);
				if (clr_row_q == AW'(IMAGE_SIDE - 1)) begin
					clr_q <= 1'b0;
				end
			end
			wr_rd_q <= req.wr_en;
			wr_wb_q <= wr_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			wrow_q   <= req.row;
			wcol_q   <= req.col;
			wwhite_q <= req.white;
		end
		if (req.rd_en) begin
			rd_col_s1 <= req.col;
		end
	end

	assign busy   = clr_q | wr_rd_q | wr_wb_q;
	assign rd_bit = word_q[rd_col_s1];

endmodule

`default_nettype wire

[hdl/segment_mask_crossing_test.sv]
// top level of the segment mask crossing test
// pixel write: mask row read then written back, next beat taken once the row is written back
// query: squares, bitwise square root, then n + 1 sample reads at one per cycle
//   with n = 1 + ceil(length), then the result beat once the output is free
// reset: mask cleared one row per cycle with no beat taken; size registers at 512
`default_nettype none

module segment_mask_crossing_test (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pixel_x, pixel_y, pixel_white, start_x, start_y, start_z, end_x, end_y, end_z
	input  wire logic [127:0] s_tdata,
	// opcode
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// crosses
	output logic [7:0]        m_tdata
);
	import segc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_LEN, ST_WALK, ST_DONE} st_t;

	localparam int PX_LO = 0;
	localparam int PY_LO = PX_LO + AW;
	localparam int PW_LO = PY_LO + AW;
	localparam int SX_LO = PW_LO + 1;
	localparam int SY_LO = SX_LO + CW;
	localparam int SZ_LO = SY_LO + CW;
	localparam int EX_LO = SZ_LO + ZW;
	localparam int EY_LO = EX_LO + CW;
	localparam int EZ_LO = EY_LO + CW;

	st_t             st_q;
	logic [DIMW-1:0] width_q, height_q;
	logic [CW-1:0]   sx_q, sy_q, ex_q, ey_q;
	logic            run_q, found_q, m_tvalid_q, crosses_q;
	logic            valid_s1, last_s1, in_s1;

	logic            s_acc, is_query, wr_inside, cfg_wr, pix;
	op_t             op;
	reg_idx_t        idx;
	logic [AW-1:0]   px, py;
	logic [CW-1:0]   in_sx, in_sy, in_ex, in_ey;
	logic signed [ZW-1:0] in_sz, in_ez;
	mask_req_t       mreq;
	logic            mask_busy, rd_bit;
	logic            len_done;
	logic [NW-1:0]   len_n;
	smp_t            smp;

	assign op       = op_t'(s_tuser);
	assign px       = s_tdata[PX_LO +: AW];
	assign py       = s_tdata[PY_LO +: AW];
	assign in_sx    = s_tdata[SX_LO +: CW];
	assign in_sy    = s_tdata[SY_LO +: CW];
	assign in_sz    = $signed(s_tdata[SZ_LO +: ZW]);
	assign in_ex    = s_tdata[EX_LO +: CW];
	assign in_ey    = s_tdata[EY_LO +: CW];
	assign in_ez    = $signed(s_tdata[EZ_LO +: ZW]);

	assign s_tready  = (st_q == ST_IDLE) && !mask_busy;
	assign s_acc     = s_tvalid && s_tready;
	assign is_query  = (op == OP_QUERY);
	assign wr_inside = (DIMW'(px) < width_q) && (DIMW'(py) < height_q);

	assign mreq.wr_en = s_acc && !is_query && wr_inside;
	assign mreq.rd_en = smp.valid;
	assign mreq.row   = mreq.wr_en ? py : smp.y;
	assign mreq.col   = mreq.wr_en ? px : smp.x;
	assign mreq.white = s_tdata[PW_LO];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[DIMW-1:0];
				REG_HEIGHT: height_q <= pwdata[DIMW-1:0];
				default:    ;
			endcase
		end
	end

	segc_len u_len (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_acc && is_query),
		.sx     (in_sx),
		.sy     (in_sy),
		.sz     (in_sz),
		.ex     (in_ex),
		.ey     (in_ey),
		.ez     (in_ez),
		.done   (len_done),
		.n      (len_n)
	);

	segc_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (len_done),
		.n      (len_n),
		.sx     (sx_q),
		.sy     (sy_q),
		.ex     (ex_q),
		.ey     (ey_q),
		.smp    (smp)
	);

	segc_mask u_mask (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.busy   (mask_busy),
		.rd_bit (rd_bit)
	);

	always_ff @(posedge clk) begin
		if (s_acc && is_query) begin
			sx_q <= in_sx;
			sy_q <= in_sy;
			ex_q <= in_ex;
			ey_q <= in_ey;
		end
		in_s1 <= (DIMW'(smp.x) < width_q) && (DIMW'(smp.y) < height_q);
	end

	assign pix = rd_bit && in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			run_q      <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			crosses_q  <= 1'b0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			valid_s1 <= smp.valid;
			last_s1  <= smp.last;
			if (m_tvalid_q && m_tready && st_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (s_acc && is_query) begin
						run_q   <= 1'b0;
						found_q <= 1'b0;
						st_q    <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (len_done) begin
						st_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (valid_s1) begin
						if (pix) begin
							run_q <= 1'b1;
						end else if (run_q) begin
							run_q   <= 1'b0;
							found_q <= 1'b1;
						end
						if (last_s1) begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						crosses_q  <= found_q;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, crosses_q};

endmodule

`default_nettype wire

[hdl/segc_checker.sv]
// port-level checker of the segment mask crossing test and its bind
`default_nettype none
`include "segment_mask_crossing_test_defines.svh"

module segc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [7:0]   m_tdata
);

	// a query beat keeps the input closed while it works
	`SMC_ASSERT_NXT(a_query_blocks, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready, "query beat did not close the input")

	// a result never shows up the cycle after an input beat
	`SMC_ASSERT_NXT(a_no_instant_result, clk, arst_n, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result right after an input beat")

	// result beat holds while stalled
	`SMC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")

	// only the crosses bit may be set
	`SMC_ASSERT_IMP(a_out_pad, clk, arst_n, m_tvalid, m_tdata[7:1] == 7'd0, "result padding not zero")

endmodule

bind segment_mask_crossing_test segc_checker u_segc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[tb/segment_mask_crossing_test_tb.sv]
// self-checking testbench of the segment mask crossing test: mask writes, segment queries, size registers
module segment_mask_crossing_test_tb;
	import segc_pkg::*;

	localparam logic [2:0] REG_IMAGE_WIDTH  = {REG_WIDTH, 2'b00};
	localparam logic [2:0] REG_IMAGE_HEIGHT = {REG_HEIGHT, 2'b00};
	localparam int FR            = 1 << FRACTION_BITS;
	localparam int MAX_XY        = (1 << CW) - 1;
	localparam int Z_MIN         = -(1 << (ZW - 1));
	localparam int Z_MAX         = (1 << (ZW - 1)) - 1;
	localparam int LIMIT_CYCLES  = 6000000;
	localparam int HOLD_CYCLES   = 2000;
	localparam int SETTLE_CYCLES = 40;

	// s_tdata layout, lowest bits last
	typedef struct packed {
		logic [4:0]           pad;
		logic signed [ZW-1:0] end_z;
		logic [CW-1:0]        end_y;
		logic [CW-1:0]        end_x;
		logic signed [ZW-1:0] start_z;
		logic [CW-1:0]        start_y;
		logic [CW-1:0]        start_x;
		logic                 pixel_white;
		logic [AW-1:0]        pixel_y;
		logic [AW-1:0]        pixel_x;
	} beat_fields_t;

	class crossing_scoreboard;
		bit [IMAGE_SIDE-1:0] mask_rows [IMAGE_SIDE];
		int unsigned width_reg;
		int unsigned height_reg;
		logic [7:0] expected_q [$];
		int mismatches;
		int writes;
		int queries;
		int crossing_count;
		int results_seen;

		function new();
			foreach (mask_rows[r]) mask_rows[r] = '0;
			width_reg = IMAGE_SIDE;
			height_reg = IMAGE_SIDE;
			mismatches = 0;
			writes = 0;
			queries = 0;
			crossing_count = 0;
			results_seen = 0;
		endfunction

		function void set_size(int unsigned w, int unsigned h);
			width_reg = w & ((1 << DIMW) - 1);
			height_reg = h & ((1 << DIMW) - 1);
		endfunction

		function bit inside_image(longint x, longint y);
			longint w_eff;
			longint h_eff;
			w_eff = (width_reg > IMAGE_SIDE) ? IMAGE_SIDE : width_reg;
			h_eff = (height_reg > IMAGE_SIDE) ? IMAGE_SIDE : height_reg;
			return x < w_eff && y < h_eff;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %0d, %s: expected %h, got %h", mismatches, what, want, got);
		endfunction

		// walk the sample points of the segment and look for a white run closed by black
		function bit segment_crosses(beat_fields_t f);
			longint sx, sy, ex, ey, dx, dy, dz, sq, root, n, den, i, px, py;
			int b;
			bit in_white;
			bit found;
			sx = f.start_x;
			sy = f.start_y;
			ex = f.end_x;
			ey = f.end_y;
			dx = ex - sx;
			dy = ey - sy;
			dz = longint'($signed(f.end_z)) - longint'($signed(f.start_z));
			sq = dx * dx + dy * dy + dz * dz;
			root = 0;
			for (b = 20; b >= 0; b--) begin
				if ((root + (longint'(1) << b)) * (root + (longint'(1) << b)) <= sq)
					root += longint'(1) << b;
			end
			if (root * root != sq)
				root++;
			n = 1 + ((root + FR - 1) >> FRACTION_BITS);
			den = n << FRACTION_BITS;
			in_white = 1'b0;
			found = 1'b0;
			for (i = 0; i <= n; i++) begin
				px = (sx * (n - i) + ex * i) / den;
				py = (sy * (n - i) + ey * i) / den;
				if (inside_image(px, py) && mask_rows[py][px]) begin
					in_white = 1'b1;
				end else if (in_white) begin
					in_white = 1'b0;
					found = 1'b1;
				end
			end
			return found;
		endfunction

		function void note_beat(logic op, beat_fields_t f);
			logic [7:0] answer;
			if (op == OP_WRITE) begin
				writes++;
				if (inside_image(f.pixel_x, f.pixel_y))
					mask_rows[f.pixel_y][f.pixel_x] = f.pixel_white;
			end else begin
				queries++;
				answer = {7'b0, segment_crosses(f)};
				crossing_count += answer[0];
				expected_q = {expected_q, answer};
			end
		endfunction

		function void check_result(logic [7:0] got);
			logic [7:0] want;
			results_seen++;
			if (expected_q.size() == 0) begin
				flag($sformatf("result beat %0d with no query pending", results_seen), 'x, got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want)
					flag($sformatf("crosses of result beat %0d", results_seen), want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	// pixel_x, pixel_y, pixel_white, start_x, start_y, start_z, end_x, end_y, end_z
	logic [127:0] s_tdata;
	// opcode
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	// crosses
	logic [7:0] m_tdata;

	crossing_scoreboard sb;
	bit gaps_on;
	bit steady_ready;
	bit hold_off_request;
	int unsigned cur_w;
	int unsigned cur_h;
	int size_settings;
	int cycle_count;

	segment_mask_crossing_test u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_stretch();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int clamp_coord(int v);
		return v < 0 ? 0 : (v > MAX_XY ? MAX_XY : v);
	endfunction

	function automatic beat_fields_t random_fields();
		beat_fields_t f;
		f = beat_fields_t'({$urandom, $urandom, $urandom, $urandom});
		f.pad = '0;
		return f;
	endfunction

	task automatic send_item(input logic op, input beat_fields_t f);
		int gap;
		gap = gaps_on ? idle_stretch() : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_beat(op, f);
	endtask

	task automatic pixel_write(input int x, input int y, input bit white);
		beat_fields_t f;
		f = random_fields();
		f.pixel_x = AW'(x);
		f.pixel_y = AW'(y);
		f.pixel_white = white;
		send_item(OP_WRITE, f);
	endtask

	task automatic segment_query(input int sx, input int sy, input int sz,
			input int ex, input int ey, input int ez);
		beat_fields_t f;
		f = random_fields();
		f.start_x = CW'(sx);
		f.start_y = CW'(sy);
		f.start_z = ZW'(sz);
		f.end_x = CW'(ex);
		f.end_y = CW'(ey);
		f.end_z = ZW'(ez);
		send_item(OP_QUERY, f);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wr ? data : $urandom;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (!wr && prdata !== data)
			sb.flag($sformatf("register read at %0d", addr), data, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_image_size(input int unsigned w, input int unsigned h);
		apb_access(1'b1, REG_IMAGE_WIDTH, w);
		apb_access(1'b1, REG_IMAGE_HEIGHT, h);
		sb.set_size(w, h);
		cur_w = sb.width_reg;
		cur_h = sb.height_reg;
		apb_access(1'b0, REG_IMAGE_WIDTH, cur_w);
		apb_access(1'b0, REG_IMAGE_HEIGHT, cur_h);
		size_settings++;
	endtask

	// stop offering beats and let every pending query and write finish
	task automatic drain_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly a few mask writes followed by a query through them, sometimes noise
	task automatic random_step();
		int r, cx, cy, k, ux, uy, j, span, off, fx, fy, sxq, syq, exq, eyq, area_w, area_h;
		r = $urandom_range(0, 99);
		area_w = (cur_w == 0 || cur_w > IMAGE_SIDE) ? IMAGE_SIDE : cur_w;
		area_h = (cur_h == 0 || cur_h > IMAGE_SIDE) ? IMAGE_SIDE : cur_h;
		if (r < 78) begin
			cx = $urandom_range(0, area_w - 1);
			cy = $urandom_range(0, area_h - 1);
			k = $urandom_range(1, 3);
			ux = $urandom_range(0, 1);
			uy = $urandom_range(0, 1);
			for (j = 0; j < k; j++)
				pixel_write((cx + j * ux > 511) ? 511 : cx + j * ux,
					(cy + j * uy > 511) ? 511 : cy + j * uy, $urandom_range(0, 99) < 85);
			span = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
			fx = $urandom_range(0, FR - 1);
			fy = $urandom_range(0, FR - 1);
			off = $urandom_range(0, 2 * span * FR);
			sxq = cx * FR + fx + off - span * FR;
			off = $urandom_range(0, 2 * span * FR);
			syq = cy * FR + fy + off - span * FR;
			if ($urandom_range(0, 3) == 0) begin
				// ends on the written pixels
				fx = $urandom_range(0, FR - 1);
				fy = $urandom_range(0, FR - 1);
				exq = cx * FR + fx;
				eyq = cy * FR + fy;
			end else begin
				off = $urandom_range(0, 127);
				exq = 2 * cx * FR + FR - sxq + off - 64;
				off = $urandom_range(0, 127);
				eyq = 2 * cy * FR + FR - syq + off - 64;
			end
			segment_query(clamp_coord(sxq), clamp_coord(syq), int'($urandom_range(0, 1023)) - 512,
				clamp_coord(exq), clamp_coord(eyq), int'($urandom_range(0, 1023)) - 512);
		end else if (r < 86) begin
			pixel_write($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1));
		end else if (r < 96) begin
			sxq = $urandom_range(0, MAX_XY);
			syq = $urandom_range(0, MAX_XY);
			off = $urandom_range(0, 80 * FR);
			exq = sxq + off - 40 * FR;
			off = $urandom_range(0, 80 * FR);
			eyq = syq + off - 40 * FR;
			segment_query(sxq, syq, int'($urandom_range(0, 4095)) - 2048,
				clamp_coord(exq), clamp_coord(eyq), int'($urandom_range(0, 4095)) - 2048);
		end else begin
			segment_query($urandom_range(0, MAX_XY), $urandom_range(0, MAX_XY),
				int'($urandom_range(0, 262143)) + Z_MIN, $urandom_range(0, MAX_XY),
				$urandom_range(0, MAX_XY), int'($urandom_range(0, 262143)) + Z_MIN);
		end
	endtask

	task automatic random_phase(input int unsigned w, input int unsigned h, input int count,
			input bit hold);
		int target;
		drain_block();
		set_image_size(w, h);
		if (hold)
			hold_off_request = 1'b1;
		target = sb.writes + sb.queries + count;
		while (sb.writes + sb.queries < target) random_step();
	endtask

	// result side: random stalls or steady ready, one long hold-off on request
	initial begin
		int seg_left;
		int hold_count;
		bit ready_level;
		m_tready = 1'b0;
		seg_left = 0;
		ready_level = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				m_tready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
				seg_left = 0;
			end else if (steady_ready) begin
				m_tready <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = idle_stretch();
					ready_level = (seg_left == 0);
					if (seg_left == 0)
						seg_left = $urandom_range(1, 16);
				end
				m_tready <= ready_level;
				seg_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE;
		gaps_on = 1'b1;
		steady_ready = 1'b0;
		hold_off_request = 1'b0;
		cur_w = IMAGE_SIDE;
		cur_h = IMAGE_SIDE;
		size_settings = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corners, run closed by black, run lasting to the end, zero length, length from z
		pixel_write(0, 0, 1'b1);
		pixel_write(511, 511, 1'b1);
		pixel_write(1, 0, 1'b0);
		segment_query(0, 0, 0, 2 * FR, 0, 0);
		segment_query(2 * FR, 0, 0, 0, 0, 0);
		segment_query(0, 0, 0, 0, 0, 0);
		segment_query(MAX_XY, MAX_XY, Z_MAX, MAX_XY, MAX_XY, Z_MAX);
		segment_query(MAX_XY, MAX_XY, 0, 509 * FR, MAX_XY, 0);
		segment_query(0, 0, Z_MIN, 2 * FR, 0, Z_MAX);
		segment_query(0, 0, Z_MIN, MAX_XY, MAX_XY, Z_MAX);
		pixel_write(0, 0, 1'b0);
		segment_query(0, 0, 0, 2 * FR, 0, 0);

		// zero width: writes dropped, every query answers zero
		drain_block();
		set_image_size(0, IMAGE_SIDE);
		pixel_write(5, 5, 1'b1);
		segment_query(4 * FR, 5 * FR, 0, 8 * FR, 5 * FR, 0);
		segment_query(MAX_XY, MAX_XY, 0, 509 * FR, MAX_XY, 0);

		// oversized registers act as the full image
		drain_block();
		set_image_size(1023, 1023);
		pixel_write(511, 0, 1'b1);
		segment_query(511 * FR, 0, 0, 505 * FR, 0, 0);

		// one pixel image, samples beyond it read black
		drain_block();
		set_image_size(1, 1);
		pixel_write(0, 0, 1'b1);
		pixel_write(1, 0, 1'b1);
		segment_query(0, 0, 0, 2 * FR, 0, 0);
		segment_query(FR, 0, 0, 0, 0, 0);

		random_phase(IMAGE_SIDE, IMAGE_SIDE, 250, 1'b0);
		gaps_on = 1'b0;
		steady_ready = 1'b1;
		random_phase($urandom_range(16, 200), $urandom_range(16, 200), 150, 1'b0);
		gaps_on = 1'b1;
		steady_ready = 1'b0;
		random_phase(IMAGE_SIDE, $urandom_range(200, 511), 200, 1'b1);
		random_phase($urandom_range(1, IMAGE_SIDE), $urandom_range(1, IMAGE_SIDE), 150, 1'b0);
		drain_block();

		$display("covered %0d mask writes and %0d segment queries (%0d crossing) over %0d size settings",
			sb.writes, sb.queries, sb.crossing_count, size_settings);
		$display("result beats checked: %0d, mismatches: %0d, still pending: %0d",
			sb.results_seen, sb.mismatches, sb.expected_q.size());
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[segment_mask_crossing_test.f]
+incdir+hdl
hdl/segc_pkg.sv
hdl/segc_len.sv
hdl/segc_walk.sv
hdl/segc_mask.sv
hdl/segment_mask_crossing_test.sv
hdl/segc_checker.sv
tb/segment_mask_crossing_test_tb.sv
